// File: hw/rtl/sle_pkg.sv
// Shared types and constants for the sequential list engine.
// No dependencies; imported by sle_cell and sequential_list_engine_core.
package sle_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_AMEND  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_POS   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // cell operations
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_UP   = 2'd1;
    localparam logic [1:0] CELL_DOWN = 2'd2;
    localparam logic [1:0] CELL_LOAD = 2'd3;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [4:0]               position;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] new_value;
    } req_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] found_position;
        logic [4:0] list_length;
    } rsp_item_t;

    typedef struct packed {
        logic [1:0] op;
        logic       cmp_en;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/sle_cell.sv
// One list cell: holds a single entry and a registered match flag.
// Depends on sle_pkg.
module sle_cell
    import sle_pkg::*;
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] load_data,
    input  logic signed [DATA_W-1:0] lower_data,
    input  logic signed [DATA_W-1:0] upper_data,
    output logic signed [DATA_W-1:0] data,
    output logic                     match
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     match_reg;
    logic                     match_next;

    always_comb
    begin
        case (ctrl.op)
            CELL_UP:   data_next = lower_data;
            CELL_DOWN: data_next = upper_data;
            CELL_LOAD: data_next = load_data;
            default:   data_next = data_reg;
        endcase
        match_next = ctrl.cmp_en ? (data_reg == key) : match_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// File: hw/rtl/sequential_list_engine_core.sv
// Top level of the sequential list engine: control and a chain of sle_cell.
// Depends on sle_pkg and sle_cell.
//
// Usage:
//   Commands arrive on the req channel (valid/ready, packed req_item_t) and
//   each produces exactly one response item on the rsp channel (rsp_item_t).
//   Commands: insert at a 1-based position, delete at a position, search for
//   a value, amend the first match with new_value.
//   At the accepting edge every cell compares its entry with the search key
//   in parallel and registers its match flag. In the execute state, once the
//   output register is free, the first match is encoded, the cells shift or
//   load as one row, and the response is written to the output register.
//   One item is in progress at a time; a new item is taken only after the
//   last has updated; match flags are registered between compare and update.
//   Reset clears the entry count and the control state; the entries
//   themselves are not cleared since slots beyond the count are never read.
//   When the receiver stalls, the response waits in the output register; a
//   new item is still taken and its compare done, and the update then holds
//   until the output register frees.
module sequential_list_engine_core
    import sle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                 state_reg;
    logic                 state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    req_item_t            req_reg;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    rsp_item_t            rsp_reg;
    rsp_item_t            rsp_next;

    logic                 req_fire;
    logic                 exec_go;
    cell_ctrl_t           ctrl   [CAPACITY];
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]  match;
    logic signed [DATA_W-1:0] load_data;

    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [1:0]           status;
    logic [CNT_W-1:0]     found_pos;
    logic                 ins_ok;
    logic                 del_ok;
    logic                 amd_ok;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    // update only when the output register is free or being emptied
    assign exec_go   = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);

    // first matching live entry
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--)
        begin
            if (match[k] && (CNT_W'(k) < count_reg))
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(k);
            end
        end
    end

    // decode the command against the current count
    always_comb
    begin
        ins_ok    = 1'b0;
        del_ok    = 1'b0;
        amd_ok    = 1'b0;
        status    = ST_OK;
        found_pos = '0;
        case (req_reg.cmd)
            CMD_INSERT:
            begin
                if (req_reg.position == '0 ||
                    {1'b0, req_reg.position} > ({1'b0, count_reg} + 6'd1))
                    status = ST_BAD_POS;
                else if (count_reg == CNT_W'(CAPACITY))
                    status = ST_FULL;
                else
                    ins_ok = 1'b1;
            end
            CMD_DELETE:
            begin
                if (req_reg.position == '0 || req_reg.position > count_reg)
                    status = ST_BAD_POS;
                else
                    del_ok = 1'b1;
            end
            default:
            begin
                if (hit)
                begin
                    found_pos = CNT_W'(hit_idx) + CNT_W'(1);
                    amd_ok    = (req_reg.cmd == CMD_AMEND);
                end
                else
                    status = ST_NOT_FOUND;
            end
        endcase
    end

    assign load_data = ins_ok ? req_reg.value : req_reg.new_value;

    // per-cell control: shift up above the insert point, down from the
    // delete point, load at the target slot
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            ctrl[k].cmp_en = req_fire;
            ctrl[k].op     = CELL_HOLD;
            if (exec_go)
            begin
                if (ins_ok)
                begin
                    if (CNT_W'(k) + CNT_W'(1) == req_reg.position)
                        ctrl[k].op = CELL_LOAD;
                    else if (CNT_W'(k) >= req_reg.position)
                        ctrl[k].op = CELL_UP;
                end
                else if (del_ok)
                begin
                    if (CNT_W'(k) + CNT_W'(1) >= req_reg.position)
                        ctrl[k].op = CELL_DOWN;
                end
                else if (amd_ok)
                begin
                    if (IDX_W'(k) == hit_idx)
                        ctrl[k].op = CELL_LOAD;
                end
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [DATA_W-1:0] lower;
            logic signed [DATA_W-1:0] upper;
            if (g == 0)
            begin : g_first
                assign lower = '0;
            end
            else
            begin : g_mid_lo
                assign lower = cell_data[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign upper = '0;
            end
            else
            begin : g_mid_hi
                assign upper = cell_data[g+1];
            end
            sle_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl[g]),
                .key        (req.value),
                .load_data  (load_data),
                .lower_data (lower),
                .upper_data (upper),
                .data       (cell_data[g]),
                .match      (match[g])
            );
        end
    endgenerate

    // sequencing, count and output register
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        if (req_fire)
            state_next = S_EXEC;
        if (exec_go)
        begin
            if (ins_ok)
                count_next = count_reg + CNT_W'(1);
            else if (del_ok)
                count_next = count_reg - CNT_W'(1);
            rsp_next.status         = status;
            rsp_next.found_position = 5'(found_pos);
            rsp_next.list_length    = 5'(count_next);
            rsp_valid_next          = 1'b1;
            state_next              = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // hold the command and the response payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
            req_reg <= req;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
